// ===== src/bbt_pkg.sv =====
// shared types and constants for the pixel bounding box tracker
// no dependencies
package bbt_pkg;

    localparam int MAX_DIM_DEF = 4096;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int PIX_W     = 32;
    localparam int POS_W     = 12;
    localparam int SIZE_W    = 13;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 56;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_MODE  = 2'd2;

    typedef enum logic [1:0] {
        MODE_ALPHA = 2'd0,
        MODE_ANY   = 2'd1,
        MODE_DIFF  = 2'd2
    } mode_t;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  rect_left;
        logic [POS_W-1:0]  rect_top;
        logic [SIZE_W-1:0] rect_width;
        logic [SIZE_W-1:0] rect_height;
    } result_t;

endpackage

// ===== src/pixel_bounding_box_tracker_core.sv =====
// top level of the pixel bounding box tracker: stream ports, config registers
// depends on bbt_pkg, bbt_select, bbt_track
//
// Pixels of a frame arrive in raster order, one per transfer, each with the base image pixel
// at the same position. The block finds the bounding rectangle of the selected pixels (mode 0:
// alpha nonzero, mode 1: any byte nonzero, mode 2/3: differs from base, two fully transparent
// pixels count as equal) and after the last pixel of each frame sends one result, with found=0
// and all-zero fields when nothing was selected; the tracker then starts clean for the next
// frame. It takes one pixel per clock: a pixel passes an input register, then the selection
// test and min/max update feed the result register, which takes the rectangle when the last
// pixel is taken. Only the end-of-frame pixel waits when a result is still untaken. A zero frame
// dimension acts as one, a value above MAX_DIM acts as MAX_DIM; register writes take effect on
// the next pixel and do not clear a frame in progress.
module pixel_bounding_box_tracker_core
    import bbt_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // pixel[31:0], base_pixel[63:32]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // rect_left, rect_top, rect_width, rect_height, pad
    output logic                  m_tuser    // found
);

    logic [CFG_W-1:0] frame_width_reg, frame_height_reg;
    mode_t            select_mode_reg;

    logic             in_valid_reg;
    logic [PIX_W-1:0] pixel_reg, base_pixel_reg;

    logic    selected;
    logic    take;
    result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= CFG_W'(1);
            frame_height_reg <= CFG_W'(1);
            select_mode_reg  <= MODE_ALPHA;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                REG_SELECT_MODE:  select_mode_reg  <= mode_t'(cfg_data[1:0]);
                default:          ;
            endcase
        end
    end

    assign s_tready = !in_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            pixel_reg      <= s_tdata[31:0];
            base_pixel_reg <= s_tdata[63:32];
        end
    end

    bbt_select u_select (
        .select_mode (select_mode_reg),
        .pixel       (pixel_reg),
        .base_pixel  (base_pixel_reg),
        .selected    (selected)
    );

    bbt_track #(
        .MAX_DIM (MAX_DIM)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .in_valid     (in_valid_reg),
        .selected     (selected),
        .take         (take),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .result       (result)
    );

    assign m_tuser = result.found;
    assign m_tdata = {6'd0, result.rect_height, result.rect_width,
                      result.rect_top, result.rect_left};

    a_empty_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("empty frame result carries nonzero rectangle");

    a_found_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[36:24] != '0 && m_tdata[49:37] != '0))
        else $error("found result with zero-sized rectangle");

    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && m_tvalid && !m_tready))
        else $error("input stalled without a held result");

endmodule

// ===== src/bbt_select.sv =====
// pixel selection test for the bounding box tracker
// depends on bbt_pkg
module bbt_select
    import bbt_pkg::*;
(
    input  mode_t            select_mode,
    input  logic [PIX_W-1:0] pixel,
    input  logic [PIX_W-1:0] base_pixel,
    output logic             selected
);

    logic [7:0] pixel_alpha;
    logic [7:0] base_alpha;

    assign pixel_alpha = pixel[31:24];
    assign base_alpha  = base_pixel[31:24];

    always_comb
    begin
        case (select_mode)
            MODE_ALPHA: selected = (pixel_alpha != 8'd0);
            MODE_ANY:   selected = (pixel != '0);
            default:
            begin
                // two fully transparent pixels match whatever their colors
                selected = (pixel_alpha != base_alpha) ||
                           ((pixel_alpha != 8'd0) && (pixel[23:0] != base_pixel[23:0]));
            end
        endcase
    end

endmodule

// ===== src/bbt_track.sv =====
// raster position counters, min/max tracking and result register
// depends on bbt_pkg
module bbt_track
    import bbt_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CFG_W-1:0] frame_width,
    input  logic [CFG_W-1:0] frame_height,
    input  logic             in_valid,
    input  logic             selected,
    output logic             take,
    output logic             out_valid,
    input  logic             out_ready,
    output result_t          result
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int EW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

    logic [CW-1:0] col_reg, row_reg;
    logic [CW-1:0] min_col_reg, min_row_reg, max_col_reg, max_row_reg;
    logic          any_reg;
    logic          out_valid_reg;
    result_t       result_reg;

    logic [EW-1:0] wide_w, wide_h;
    logic [CW:0]   eff_w, eff_h;
    logic          col_last, row_last, frame_end, out_free;
    logic [CW-1:0] min_col_next, min_row_next, max_col_next, max_row_next;
    logic          any_next;
    result_t       result_next;

    // zero acts as one, oversize clamps to the maximum
    always_comb
    begin
        wide_w = EW'(frame_width);
        wide_h = EW'(frame_height);
        if (wide_w == '0)
            eff_w = (CW + 1)'(1);
        else if (wide_w > EW'(MAX_DIM))
            eff_w = (CW + 1)'(MAX_DIM);
        else
            eff_w = wide_w[CW:0];
        if (wide_h == '0)
            eff_h = (CW + 1)'(1);
        else if (wide_h > EW'(MAX_DIM))
            eff_h = (CW + 1)'(MAX_DIM);
        else
            eff_h = wide_h[CW:0];
    end

    assign col_last  = ({1'b0, col_reg} + (CW + 1)'(1)) >= eff_w;
    assign row_last  = ({1'b0, row_reg} + (CW + 1)'(1)) >= eff_h;
    assign frame_end = col_last && row_last;
    assign out_free  = !out_valid_reg || out_ready;
    assign take      = in_valid && (!frame_end || out_free);

    always_comb
    begin
        min_col_next = (selected && col_reg < min_col_reg) ? col_reg : min_col_reg;
        min_row_next = (selected && row_reg < min_row_reg) ? row_reg : min_row_reg;
        max_col_next = (selected && col_reg > max_col_reg) ? col_reg : max_col_reg;
        max_row_next = (selected && row_reg > max_row_reg) ? row_reg : max_row_reg;
        any_next     = any_reg || selected;

        result_next.found = any_next;
        if (any_next)
        begin
            result_next.rect_left   = POS_W'(min_col_next);
            result_next.rect_top    = POS_W'(min_row_next);
            result_next.rect_width  = SIZE_W'({1'b0, max_col_next} - {1'b0, min_col_next}
                                              + (CW + 1)'(1));
            result_next.rect_height = SIZE_W'({1'b0, max_row_next} - {1'b0, min_row_next}
                                              + (CW + 1)'(1));
        end
        else
        begin
            result_next.rect_left   = '0;
            result_next.rect_top    = '0;
            result_next.rect_width  = '0;
            result_next.rect_height = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            min_col_reg <= '1;
            min_row_reg <= '1;
            max_col_reg <= '0;
            max_row_reg <= '0;
            any_reg     <= 1'b0;
        end
        else if (take)
        begin
            if (frame_end)
            begin
                col_reg     <= '0;
                row_reg     <= '0;
                min_col_reg <= '1;
                min_row_reg <= '1;
                max_col_reg <= '0;
                max_row_reg <= '0;
                any_reg     <= 1'b0;
            end
            else
            begin
                min_col_reg <= min_col_next;
                min_row_reg <= min_row_next;
                max_col_reg <= max_col_next;
                max_row_reg <= max_row_next;
                any_reg     <= any_next;
                if (col_last)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + CW'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take && frame_end)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take && frame_end)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ===== sim/testbench.sv =====
// testbench for pixel_bounding_box_tracker_core: directed table, then random frames
// checks each bounding box result against a cycle-free predictor of the tracker
// depends on bbt_pkg and the tracker rtl
module testbench;
    import bbt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int IDLE_PCT     = 32;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 950;

    typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_W-1:0]      reg_val;
        logic [PIX_W-1:0]      pix;
        logic [PIX_W-1:0]      base;
        logic                  typed;
        result_t               want;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // pixel, base_pixel
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // rect_left, rect_top, rect_width, rect_height, pad
    logic                  m_tuser;   // found

    // predictor state
    logic [CFG_W-1:0]  frame_w;
    logic [CFG_W-1:0]  frame_h;
    logic [1:0]        sel_mode;
    logic [POS_W-1:0]  col_pos;
    logic [POS_W-1:0]  row_pos;
    logic [POS_W-1:0]  min_col;
    logic [POS_W-1:0]  min_row;
    logic [POS_W-1:0]  max_col;
    logic [POS_W-1:0]  max_row;
    logic              seen_any;

    result_t   pending_boxes[$];
    plan_row_t plan[$];
    int        box_errors = 0;
    int        stall_cycles = 0;
    int        hold_trigger = 0;
    int        hold_seen = 0;
    int        hold_left = 0;
    bit        quiet = 1'b0;
    bit        frame_closed;

    pixel_bounding_box_tracker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #4 clk = ~clk;

    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        if (v == '0)
            return 13'd1;
        if (v > 13'(MAX_DIM_DEF))
            return 13'(MAX_DIM_DEF);
        return v;
    endfunction

    function automatic void clear_box();
        col_pos  = '0;
        row_pos  = '0;
        min_col  = 12'(MAX_DIM_DEF - 1);
        min_row  = 12'(MAX_DIM_DEF - 1);
        max_col  = '0;
        max_row  = '0;
        seen_any = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] val);
        case (idx)
            REG_FRAME_WIDTH:  frame_w = val;
            REG_FRAME_HEIGHT: frame_h = val;
            REG_SELECT_MODE:  sel_mode = val[1:0];
            default: ;
        endcase
    endfunction

    function automatic bit pixel_selected(input logic [PIX_W-1:0] p, input logic [PIX_W-1:0] b);
        if (sel_mode == MODE_ALPHA)
            return p[31:24] != 8'h00;
        if (sel_mode == MODE_ANY)
            return p != '0;
        // two fully transparent pixels count as equal
        if (p[31:24] != b[31:24])
            return 1'b1;
        if (p[31:24] == 8'h00)
            return 1'b0;
        return p[23:0] != b[23:0];
    endfunction

    // advances the tracker by one pixel, returns 1 when the frame closes
    function automatic bit track_pixel(input logic [PIX_W-1:0] p, input logic [PIX_W-1:0] b,
                                       output result_t box);
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        w = eff_dim(frame_w);
        h = eff_dim(frame_h);
        box = '0;
        if (pixel_selected(p, b)) begin
            if (col_pos < min_col) min_col = col_pos;
            if (row_pos < min_row) min_row = row_pos;
            if (col_pos > max_col) max_col = col_pos;
            if (row_pos > max_row) max_row = row_pos;
            seen_any = 1'b1;
        end
        if ({1'b0, col_pos} + 13'd1 < w) begin
            col_pos = col_pos + 12'd1;
            return 1'b0;
        end
        col_pos = '0;
        if ({1'b0, row_pos} + 13'd1 < h) begin
            row_pos = row_pos + 12'd1;
            return 1'b0;
        end
        if (seen_any) begin
            box.found       = 1'b1;
            box.rect_left   = min_col;
            box.rect_top    = min_row;
            box.rect_width  = {1'b0, max_col} - {1'b0, min_col} + 13'd1;
            box.rect_height = {1'b0, max_row} - {1'b0, min_row} + 13'd1;
        end
        clear_box();
        return 1'b1;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] val);
        plan_row_t r;
        r = '0;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic plan_row_t pix_row(input logic [PIX_W-1:0] p, input logic [PIX_W-1:0] b,
                                          input logic typed, input result_t want);
        plan_row_t r;
        r = '0;
        r.kind  = ROW_PIXEL;
        r.pix   = p;
        r.base  = b;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    task automatic report_field(input string name, input int unsigned exp_v,
                                input int unsigned act_v);
        $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
        box_errors++;
    endtask

    task automatic push_pixel(input logic [PIX_W-1:0] p, input logic [PIX_W-1:0] b,
                              input logic typed, input result_t want);
        result_t box;
        while ($urandom_range(0, 99) < (quiet ? 0 : IDLE_PCT)) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, p};
        do
            @(posedge clk);
        while (!s_tready);
        frame_closed = track_pixel(p, b, box);
        if (frame_closed)
            pending_boxes.push_back(typed ? want : box);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_boxes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        apply_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_pixel(output logic [PIX_W-1:0] p, output logic [PIX_W-1:0] b);
        int pick;
        pick = $urandom_range(0, 5);
        b = $urandom;
        case (pick)
            0: p = '0;
            1: begin
                p = {8'h00, 24'($urandom)};
                b = {8'h00, 24'($urandom)};
            end
            2: p = b;
            3: p = b ^ (32'h1 << $urandom_range(0, 31));
            default: p = $urandom;
        endcase
    endtask

    // result monitor
    always @(posedge clk) begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got.found       = m_tuser;
            got.rect_left   = m_tdata[POS_W-1:0];
            got.rect_top    = m_tdata[2*POS_W-1:POS_W];
            got.rect_width  = m_tdata[2*POS_W+SIZE_W-1:2*POS_W];
            got.rect_height = m_tdata[2*POS_W+2*SIZE_W-1:2*POS_W+SIZE_W];
            if (pending_boxes.size() == 0) begin
                $display("%0t unexpected result: found %0d left %0d top %0d", $time,
                         got.found, got.rect_left, got.rect_top);
                box_errors++;
            end else begin
                want = pending_boxes.pop_front();
                if (got.found !== want.found)
                    report_field("found", want.found, got.found);
                if (got.rect_left !== want.rect_left)
                    report_field("rect_left", want.rect_left, got.rect_left);
                if (got.rect_top !== want.rect_top)
                    report_field("rect_top", want.rect_top, got.rect_top);
                if (got.rect_width !== want.rect_width)
                    report_field("rect_width", want.rect_width, got.rect_width);
                if (got.rect_height !== want.rect_height)
                    report_field("rect_height", want.rect_height, got.rect_height);
            end
        end
    end

    // receiver, with its own hold-off counter
    always @(posedge clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles == STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [PIX_W-1:0] p;
        logic [PIX_W-1:0] b;
        int random_count;
        int frame_no;
        int n;
        int k;
        int change_at;
        int pick;
        result_t none;
        result_t unit;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        frame_w   = 13'd1;
        frame_h   = 13'd1;
        sel_mode  = MODE_ALPHA;
        clear_box();

        none = '0;
        unit = '{found: 1'b1, rect_left: '0, rect_top: '0, rect_width: 13'd1,
                 rect_height: 13'd1};

        plan.push_back(pix_row(32'hFF000000, 32'h00000000, 1'b1, unit));
        plan.push_back(pix_row(32'h00FFFFFF, 32'hFFFFFFFF, 1'b1, none));
        plan.push_back(reg_row(REG_SELECT_MODE, 13'(MODE_ANY)));
        plan.push_back(pix_row(32'h00000000, 32'hFFFFFFFF, 1'b1, none));
        plan.push_back(pix_row(32'h00000001, 32'h00000000, 1'b1, unit));
        plan.push_back(reg_row(REG_SELECT_MODE, 13'(MODE_DIFF)));
        // both transparent, colors differ
        plan.push_back(pix_row(32'h00123456, 32'h00ABCDEF, 1'b1, none));
        plan.push_back(pix_row(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, none));
        plan.push_back(pix_row(32'h80000000, 32'h81000000, 1'b1, unit));
        plan.push_back(pix_row(32'h01000000, 32'h01000001, 1'b1, unit));
        // unused mode value decodes as diff
        plan.push_back(reg_row(REG_SELECT_MODE, 13'd3));
        plan.push_back(pix_row(32'h00000000, 32'h01000000, 1'b1, unit));
        plan.push_back(reg_row(REG_UNUSED, 13'h1FFF));
        plan.push_back(reg_row(REG_SELECT_MODE, 13'(MODE_ALPHA)));
        plan.push_back(reg_row(REG_FRAME_WIDTH, 13'd3));
        plan.push_back(reg_row(REG_FRAME_HEIGHT, 13'd2));
        plan.push_back(pix_row(32'h00000000, 32'h0, 1'b0, none));
        plan.push_back(pix_row(32'hFF000000, 32'h0, 1'b0, none));
        plan.push_back(pix_row(32'h00000000, 32'h0, 1'b0, none));
        plan.push_back(pix_row(32'h01000000, 32'h0, 1'b0, none));
        plan.push_back(pix_row(32'h00FFFFFF, 32'h0, 1'b0, none));
        plan.push_back(pix_row(32'h00000000, 32'h0, 1'b0, none));
        // zero dimensions act as one
        plan.push_back(reg_row(REG_FRAME_WIDTH, 13'd0));
        plan.push_back(reg_row(REG_FRAME_HEIGHT, 13'd0));
        plan.push_back(pix_row(32'h7F000000, 32'h0, 1'b1, unit));
        // width shrinks below the current column in mid-frame
        plan.push_back(reg_row(REG_FRAME_WIDTH, 13'd4));
        plan.push_back(reg_row(REG_FRAME_HEIGHT, 13'd2));
        plan.push_back(pix_row(32'h00000000, 32'h0, 1'b0, none));
        plan.push_back(pix_row(32'h00000000, 32'h0, 1'b0, none));
        plan.push_back(pix_row(32'h01000000, 32'h0, 1'b0, none));
        plan.push_back(reg_row(REG_FRAME_WIDTH, 13'd2));
        plan.push_back(pix_row(32'h00000000, 32'h0, 1'b0, none));
        plan.push_back(pix_row(32'h01000000, 32'h0, 1'b0, none));
        plan.push_back(pix_row(32'h00000000, 32'h0, 1'b0, none));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                wait_drained();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                push_pixel(plan[i].pix, plan[i].base, plan[i].typed, plan[i].want);
            end
        end

        random_count = 0;
        frame_no = 0;
        while (random_count < RANDOM_ITEMS) begin
            quiet = (frame_no >= 15 && frame_no < 30);
            wait_drained();
            if (frame_no == 10) begin
                // receiver holds off while 1x1 frames keep coming
                write_reg(REG_FRAME_WIDTH, 13'd1);
                write_reg(REG_FRAME_HEIGHT, 13'd1);
                hold_trigger++;
                repeat (40) begin
                    random_pixel(p, b);
                    push_pixel(p, b, 1'b0, '0);
                    random_count++;
                end
                wait_drained();
            end
            pick = $urandom_range(0, 19);
            write_reg(REG_FRAME_WIDTH, pick == 0 ? 13'd0 :
                      pick == 1 ? 13'($urandom_range(9, 40)) : 13'($urandom_range(1, 8)));
            pick = $urandom_range(0, 19);
            write_reg(REG_FRAME_HEIGHT, pick == 0 ? 13'd0 :
                      pick == 1 ? 13'($urandom_range(7, 12)) : 13'($urandom_range(1, 5)));
            write_reg(REG_SELECT_MODE, 13'($urandom_range(0, 3)));
            n = int'(eff_dim(frame_w)) * int'(eff_dim(frame_h));
            change_at = (n > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, n - 1) : -1;
            k = 0;
            do begin
                if (k == change_at) begin
                    wait_drained();
                    write_reg(2'($urandom_range(0, 2)), 13'($urandom_range(0, 6)));
                end
                random_pixel(p, b);
                push_pixel(p, b, 1'b0, '0);
                k++;
                random_count++;
            end while (!frame_closed);
            frame_no++;
        end
        quiet = 1'b0;

        wait_drained();
        if (pending_boxes.size() != 0)
            box_errors++;
        if (box_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bbt_pkg.sv
src/bbt_select.sv
src/bbt_track.sv
src/pixel_bounding_box_tracker_core.sv
sim/testbench.sv
